[src/cascaded_slew_limiter_bias_defines.svh]
// ----------------------------------------------------------------------------
// Cascaded slew limiter assertion macros
// Concurrent checks on the sequencer, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef CASCADED_SLEW_LIMITER_BIAS_DEFINES_SVH
`define CASCADED_SLEW_LIMITER_BIAS_DEFINES_SVH

// check a condition in the same cycle
`define CSL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slew limiter sequencer check failed");

// check a condition in the next cycle
`define CSL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slew limiter sequencer step check failed");

`endif

[src/csl_pkg.sv]
// ----------------------------------------------------------------------------
// Cascaded slew limiter package
// Constants, control word format, microprogram and shared arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package csl_pkg;

    localparam int STAGES_DEF       = 9;
    localparam int SAMPLE_WIDTH_DEF = 24;

    localparam logic [30:0] K_0975    = 31'd1046898278;
    localparam logic [30:0] K_INV0975 = 31'd1101273666;
    localparam logic [30:0] K_PHI     = 31'd1737350766;

    localparam logic [23:0] BASE_THRESHOLD_RST = 24'd4194304;

    localparam logic signed [35:0] SAT32_MAX = 36'sd2147483647;
    localparam logic signed [35:0] SAT32_MIN = -36'sd2147483648;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE           = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_THRESHOLD   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNDER_BIAS_RECIP = 2'd2;

    localparam int PC_W = 4;
    localparam logic [PC_W-1:0] PC_IDLE      = 4'd0;
    localparam logic [PC_W-1:0] PC_CHECK     = 4'd1;
    localparam logic [PC_W-1:0] PC_TH_MUL    = 4'd2;
    localparam logic [PC_W-1:0] PC_TH_RND    = 4'd3;
    localparam logic [PC_W-1:0] PC_TGT_MUL   = 4'd4;
    localparam logic [PC_W-1:0] PC_TGT_RND   = 4'd5;
    localparam logic [PC_W-1:0] PC_DIFF      = 4'd6;
    localparam logic [PC_W-1:0] PC_STK_MUL1  = 4'd7;
    localparam logic [PC_W-1:0] PC_STK_MUL2  = 4'd8;
    localparam logic [PC_W-1:0] PC_STK_APPLY = 4'd9;
    localparam logic [PC_W-1:0] PC_CLAMP     = 4'd10;
    localparam logic [PC_W-1:0] PC_PRV_MUL   = 4'd11;
    localparam logic [PC_W-1:0] PC_PRV_WR    = 4'd12;
    localparam logic [PC_W-1:0] PC_OUT       = 4'd13;
    localparam logic [PC_W-1:0] PC_RET       = 4'd14;

    typedef enum logic [3:0] {
        OP_NOP       = 4'd0,
        OP_TH_MUL    = 4'd1,
        OP_TH_RND    = 4'd2,
        OP_TGT_MUL   = 4'd3,
        OP_TGT_RND   = 4'd4,
        OP_DIFF      = 4'd5,
        OP_STK_MUL1  = 4'd6,
        OP_STK_MUL2  = 4'd7,
        OP_STK_APPLY = 4'd8,
        OP_CLAMP     = 4'd9,
        OP_PRV_MUL   = 4'd10,
        OP_PRV_WR    = 4'd11,
        OP_OUT       = 4'd12
    } dp_op_t;

    typedef enum logic [2:0] {
        COND_NONE       = 3'd0,
        COND_ALWAYS     = 3'd1,
        COND_NO_ACCEPT  = 3'd2,
        COND_BYPASS     = 3'd3,
        COND_NOSTICK    = 3'd4,
        COND_TH_MORE    = 3'd5,
        COND_STAGE_MORE = 3'd6,
        COND_OUT_BUSY   = 3'd7
    } cond_t;

    typedef enum logic [1:0] {
        CNT_HOLD = 2'd0,
        CNT_LOAD = 2'd1,
        CNT_INC  = 2'd2,
        CNT_DEC  = 2'd3
    } cnt_op_t;

    typedef struct packed {
        dp_op_t          op;
        cond_t           cond;
        logic [PC_W-1:0] target;
        cnt_op_t         cnt;
    } uword_t;

    typedef struct packed {
        dp_op_t op;
        logic   load;
        logic   out_load;
    } ctrl_t;

    function automatic uword_t csl_rom(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: PC_IDLE, cnt: CNT_HOLD};
        case (pc)
            PC_IDLE:      w = '{op: OP_NOP, cond: COND_NO_ACCEPT, target: PC_IDLE,
                                cnt: CNT_LOAD};
            PC_CHECK:     w = '{op: OP_NOP, cond: COND_BYPASS, target: PC_OUT,
                                cnt: CNT_HOLD};
            PC_TH_MUL:    w = '{op: OP_TH_MUL, cond: COND_NONE, target: PC_IDLE,
                                cnt: CNT_HOLD};
            PC_TH_RND:    w = '{op: OP_TH_RND, cond: COND_TH_MORE, target: PC_TH_MUL,
                                cnt: CNT_DEC};
            PC_TGT_MUL:   w = '{op: OP_TGT_MUL, cond: COND_NOSTICK, target: PC_CLAMP,
                                cnt: CNT_HOLD};
            PC_TGT_RND:   w = '{op: OP_TGT_RND, cond: COND_NONE, target: PC_IDLE,
                                cnt: CNT_HOLD};
            PC_DIFF:      w = '{op: OP_DIFF, cond: COND_NONE, target: PC_IDLE,
                                cnt: CNT_HOLD};
            PC_STK_MUL1:  w = '{op: OP_STK_MUL1, cond: COND_NONE, target: PC_IDLE,
                                cnt: CNT_HOLD};
            PC_STK_MUL2:  w = '{op: OP_STK_MUL2, cond: COND_NONE, target: PC_IDLE,
                                cnt: CNT_HOLD};
            PC_STK_APPLY: w = '{op: OP_STK_APPLY, cond: COND_NONE, target: PC_IDLE,
                                cnt: CNT_HOLD};
            PC_CLAMP:     w = '{op: OP_CLAMP, cond: COND_NONE, target: PC_IDLE,
                                cnt: CNT_HOLD};
            PC_PRV_MUL:   w = '{op: OP_PRV_MUL, cond: COND_NONE, target: PC_IDLE,
                                cnt: CNT_HOLD};
            PC_PRV_WR:    w = '{op: OP_PRV_WR, cond: COND_STAGE_MORE, target: PC_TGT_MUL,
                                cnt: CNT_INC};
            PC_OUT:       w = '{op: OP_OUT, cond: COND_OUT_BUSY, target: PC_OUT,
                                cnt: CNT_HOLD};
            PC_RET:       w = '{op: OP_NOP, cond: COND_ALWAYS, target: PC_IDLE,
                                cnt: CNT_HOLD};
            default:      w = '{op: OP_NOP, cond: COND_ALWAYS, target: PC_IDLE,
                                cnt: CNT_HOLD};
        endcase
        return w;
    endfunction

    // product times a Q1.30 constant, round half away from zero, sign applied
    function automatic logic signed [35:0] rnd_q30(input logic [64:0] prod,
                                                   input logic neg);
        logic [65:0]        sum;
        logic signed [35:0] mag;
        sum = {1'b0, prod} + (66'd1 << 29);
        mag = signed'(sum[65:30]);
        return neg ? -mag : mag;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > SAT32_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SAT32_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = signed'(v[31:0]);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/csl_seq.sv]
// ----------------------------------------------------------------------------
// Cascaded slew limiter sequencer
// Step counter, control store lookup, conditional jumps and stage counter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cascaded_slew_limiter_bias_defines.svh"

module csl_seq #(
    parameter int STAGES = csl_pkg::STAGES_DEF,
    localparam int CNT_W = (STAGES > 1) ? $clog2(STAGES) : 1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           enable,
    input  wire logic           stick_en,
    input  wire logic           out_busy,
    output csl_pkg::ctrl_t      ctrl,
    output logic [CNT_W-1:0]    cnt
);
    import csl_pkg::*;

    localparam logic [CNT_W-1:0] LAST = CNT_W'(STAGES - 1);

    logic [PC_W-1:0]  pc_reg, pc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    uword_t           uw;
    logic             accept;
    logic             taken;

    always_comb
    begin
        uw       = csl_rom(pc_reg);
        in_ready = (pc_reg == PC_IDLE);
        accept   = in_valid && in_ready;

        case (uw.cond)
            COND_NONE:       taken = 1'b0;
            COND_ALWAYS:     taken = 1'b1;
            COND_NO_ACCEPT:  taken = !accept;
            COND_BYPASS:     taken = !enable;
            COND_NOSTICK:    taken = !stick_en;
            COND_TH_MORE:    taken = (cnt_reg != '0);
            COND_STAGE_MORE: taken = (cnt_reg != LAST);
            COND_OUT_BUSY:   taken = out_busy;
            default:         taken = 1'b0;
        endcase

        pc_next = taken ? uw.target : pc_reg + PC_W'(1);

        case (uw.cnt)
            CNT_LOAD: cnt_next = LAST;
            CNT_INC:  cnt_next = taken ? cnt_reg + CNT_W'(1) : cnt_reg;
            CNT_DEC:  cnt_next = taken ? cnt_reg - CNT_W'(1) : cnt_reg;
            default:  cnt_next = cnt_reg;
        endcase

        ctrl.op       = uw.op;
        ctrl.load     = accept;
        ctrl.out_load = (uw.op == OP_OUT) && !out_busy;
        cnt           = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= PC_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            pc_reg  <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

    `CSL_ASSERT_NEXT(a_accept_to_check, accept, pc_reg == PC_CHECK)
    `CSL_ASSERT_NEXT(a_last_stage_out, (pc_reg == PC_PRV_WR) && (cnt_reg == LAST), pc_reg == PC_OUT)
    `CSL_ASSERT_NEXT(a_th_done_stage0, (pc_reg == PC_TH_RND) && (cnt_reg == '0), (pc_reg == PC_TGT_MUL) && (cnt_reg == '0))
    `CSL_ASSERT_NOW(a_stick_steps_enabled, pc_reg == PC_STK_MUL1, stick_en && enable)

endmodule

`default_nettype wire

[src/csl_thresh.sv]
// ----------------------------------------------------------------------------
// Cascaded slew limiter threshold unit
// Builds the per-stage limits from the base value by repeated phi products.
// ----------------------------------------------------------------------------
`default_nettype none

module csl_thresh #(
    parameter int STAGES = csl_pkg::STAGES_DEF,
    localparam int CNT_W = (STAGES > 1) ? $clog2(STAGES) : 1
) (
    input  wire logic              clk,
    input  wire csl_pkg::ctrl_t    ctrl,
    input  wire logic [CNT_W-1:0]  cnt,
    input  wire logic [23:0]       base,
    output logic [29:0]            th
);
    import csl_pkg::*;

    logic [30:0]        t_reg, t_next;
    logic [61:0]        prodt_reg, prodt_next;
    logic [29:0]        th_reg [STAGES];
    logic [31:0]        tsum;
    logic signed [35:0] r;
    logic               th_we;

    always_comb
    begin
        tsum       = 32'(t_reg) + 32'd2;
        r          = rnd_q30(65'(prodt_reg), 1'b0);
        t_next     = t_reg;
        prodt_next = prodt_reg;
        th_we      = 1'b0;
        if (ctrl.load)
        begin
            t_next = 31'(base);
        end
        else
        begin
            case (ctrl.op)
                OP_TH_MUL:
                begin
                    th_we      = 1'b1;
                    prodt_next = 62'(t_reg) * 62'(K_PHI);
                end
                OP_TH_RND:
                begin
                    t_next = (r > 36'sd2147483647) ? 31'h7FFFFFFF : r[30:0];
                end
                default:
                begin
                    t_next = t_reg;
                end
            endcase
        end
        th = th_reg[cnt];
    end

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        prodt_reg <= prodt_next;
        if (th_we)
        begin
            th_reg[cnt] <= tsum[31:2];
        end
    end

endmodule

`default_nettype wire

[src/csl_lane.sv]
// ----------------------------------------------------------------------------
// Cascaded slew limiter channel datapath
// One multiplier, working registers and stage history for one channel.
// ----------------------------------------------------------------------------
`default_nettype none

module csl_lane #(
    parameter int STAGES       = csl_pkg::STAGES_DEF,
    parameter int SAMPLE_WIDTH = csl_pkg::SAMPLE_WIDTH_DEF,
    localparam int CNT_W = (STAGES > 1) ? $clog2(STAGES) : 1
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire csl_pkg::ctrl_t                  ctrl,
    input  wire logic [CNT_W-1:0]                cnt,
    input  wire logic signed [SAMPLE_WIDTH-1:0]  sample,
    input  wire logic [31:0]                     recip,
    input  wire logic [29:0]                     th,
    output logic signed [SAMPLE_WIDTH-1:0]       result
);
    import csl_pkg::*;

    localparam logic signed [35:0] SMAX36 = (36'sd1 <<< (SAMPLE_WIDTH - 1)) - 36'sd1;
    localparam logic signed [35:0] SMIN36 = -(36'sd1 <<< (SAMPLE_WIDTH - 1));

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        input logic signed [35:0] v);
        logic signed [35:0] c;
        if (v > SMAX36) begin
            c = SMAX36;
        end else if (v < SMIN36) begin
            c = SMIN36;
        end else begin
            c = v;
        end
        return signed'(c[SAMPLE_WIDTH-1:0]);
    endfunction

    logic signed [SAMPLE_WIDTH-1:0] prev_reg [STAGES];
    logic signed [31:0]             x_reg, x_next;
    logic signed [31:0]             target_reg, target_next;
    logic [32:0]                    dmag_reg, dmag_next;
    logic                           dneg_reg, dneg_next;
    logic                           stick_reg, stick_next;
    logic                           neg_reg, neg_next;
    logic [64:0]                    prod_reg, prod_next;

    logic signed [SAMPLE_WIDTH-1:0] p;
    logic signed [35:0]             p36;
    logic signed [32:0]             p33, x33, diff33;
    logic [32:0]                    pmag, xmag;
    logic signed [35:0]             rnd;
    logic signed [35:0]             th36;
    logic signed [31:0]             lo, hi;
    logic [32:0]                    mul_a;
    logic [31:0]                    mul_b;
    logic [64:0]                    mprod;
    logic                           prev_we;
    logic signed [SAMPLE_WIDTH-1:0] prev_wdata;

    always_comb
    begin
        p      = prev_reg[cnt];
        p36    = 36'(p);
        p33    = 33'(p);
        pmag   = p33[32] ? unsigned'(-p33) : unsigned'(p33);
        x33    = 33'(x_reg);
        xmag   = x33[32] ? unsigned'(-x33) : unsigned'(x33);
        diff33 = x33 - 33'(target_reg);
        rnd    = rnd_q30(prod_reg, neg_reg);
        th36   = signed'(36'(th));
        lo     = sat32(p36 - th36);
        hi     = sat32(p36 + th36);

        case (ctrl.op)
            OP_TGT_MUL:
            begin
                mul_a = pmag;
                mul_b = 32'(K_INV0975);
            end
            OP_STK_MUL1:
            begin
                mul_a = dmag_reg;
                mul_b = recip;
            end
            OP_STK_MUL2:
            begin
                mul_a = dmag_reg;
                mul_b = {2'b00, prod_reg[35:6]};
            end
            OP_PRV_MUL:
            begin
                mul_a = xmag;
                mul_b = 32'(K_0975);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mprod = 65'(mul_a) * 65'(mul_b);

        x_next      = x_reg;
        target_next = target_reg;
        dmag_next   = dmag_reg;
        dneg_next   = dneg_reg;
        stick_next  = stick_reg;
        neg_next    = neg_reg;
        prod_next   = prod_reg;
        prev_we     = 1'b0;
        prev_wdata  = sat_sample(rnd);

        if (ctrl.load)
        begin
            x_next = 32'(sample);
        end
        else
        begin
            case (ctrl.op)
                OP_TGT_MUL:
                begin
                    prod_next = mprod;
                    neg_next  = p33[32];
                end
                OP_TGT_RND:
                begin
                    target_next = sat32(rnd);
                end
                OP_DIFF:
                begin
                    dneg_next = diff33[32];
                    dmag_next = diff33[32] ? unsigned'(-diff33) : unsigned'(diff33);
                end
                OP_STK_MUL1:
                begin
                    prod_next = mprod;
                end
                OP_STK_MUL2:
                begin
                    stick_next = (prod_reg[64:36] == '0);
                    prod_next  = mprod;
                    neg_next   = dneg_reg;
                end
                OP_STK_APPLY:
                begin
                    if (stick_reg)
                    begin
                        x_next = sat32(36'(target_reg) + rnd);
                    end
                end
                OP_CLAMP:
                begin
                    if (x_reg < lo)
                    begin
                        x_next = lo;
                    end
                    else if (x_reg > hi)
                    begin
                        x_next = hi;
                    end
                end
                OP_PRV_MUL:
                begin
                    prod_next = mprod;
                    neg_next  = x_reg[31];
                end
                OP_PRV_WR:
                begin
                    prev_we = 1'b1;
                end
                default:
                begin
                    x_next = x_reg;
                end
            endcase
        end

        result = sat_sample(36'(x_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else if (prev_we)
        begin
            prev_reg[cnt] <= prev_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        target_reg <= target_next;
        dmag_reg   <= dmag_next;
        dneg_reg   <= dneg_next;
        stick_reg  <= stick_next;
        neg_reg    <= neg_next;
        prod_reg   <= prod_next;
    end

endmodule

`default_nettype wire

[src/cascaded_slew_limiter_bias.sv]
// ----------------------------------------------------------------------------
// Cascaded slew limiter with bias, stereo
// Microcoded sequencer driving two channel datapaths and a threshold unit.
//
//   channel   signals                                   transfer rule
//   input     in_valid/in_ready, sample_left/right      valid and ready high
//   output    out_valid/out_ready, out_left/right       valid and ready high
//   config    cfg_we, cfg_index, cfg_data               cfg_we high
//
// A transaction runs the threshold loop, then per stage the target, sticking,
// clamp and history steps; the sticking steps are skipped with the blend off,
// and all are skipped when disabled. The pace is set by the single multiplier
// of each channel, one product per step, two steps per threshold stage.
// Reset clears the stage history at once; no clearing pass.
// The result register holds a transaction until taken; the next input is
// accepted meanwhile, and the sequencer waits at its output step.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_slew_limiter_bias #(
    parameter int STAGES       = csl_pkg::STAGES_DEF,
    parameter int SAMPLE_WIDTH = csl_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       sample_left,
    input  wire logic signed [SAMPLE_WIDTH-1:0]       sample_right,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]            out_left,
    output logic signed [SAMPLE_WIDTH-1:0]            out_right,
    input  wire logic                                 cfg_we,
    input  wire logic [csl_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [31:0]                          cfg_data
);
    import csl_pkg::*;

    localparam int CNT_W = (STAGES > 1) ? $clog2(STAGES) : 1;

    logic                           enable_reg;
    logic [23:0]                    base_threshold_reg;
    logic [31:0]                    under_bias_recip_reg;
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_left_reg, out_right_reg;

    ctrl_t                          ctrl;
    logic [CNT_W-1:0]               cnt;
    logic [29:0]                    th;
    logic signed [SAMPLE_WIDTH-1:0] res_left, res_right;
    logic                           out_busy;
    logic                           stick_en;

    assign out_busy  = out_valid_reg && !out_ready;
    assign stick_en  = (under_bias_recip_reg != '0);
    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;

    csl_seq #(.STAGES(STAGES)) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .enable   (enable_reg),
        .stick_en (stick_en),
        .out_busy (out_busy),
        .ctrl     (ctrl),
        .cnt      (cnt)
    );

    csl_thresh #(.STAGES(STAGES)) u_thresh (
        .clk  (clk),
        .ctrl (ctrl),
        .cnt  (cnt),
        .base (base_threshold_reg),
        .th   (th)
    );

    csl_lane #(.STAGES(STAGES), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .cnt    (cnt),
        .sample (sample_left),
        .recip  (under_bias_recip_reg),
        .th     (th),
        .result (res_left)
    );

    csl_lane #(.STAGES(STAGES), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_lane_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .cnt    (cnt),
        .sample (sample_right),
        .recip  (under_bias_recip_reg),
        .th     (th),
        .result (res_right)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg           <= 1'b0;
            base_threshold_reg   <= BASE_THRESHOLD_RST;
            under_bias_recip_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:           enable_reg           <= cfg_data[0];
                CFG_BASE_THRESHOLD:   base_threshold_reg   <= cfg_data[23:0];
                CFG_UNDER_BIAS_RECIP: under_bias_recip_reg <= cfg_data;
                default:              enable_reg           <= enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_left_reg  <= res_left;
            out_right_reg <= res_right;
        end
    end

endmodule

`default_nettype wire

[tb/sv/cascaded_slew_limiter_bias_tb.sv]
// ----------------------------------------------------------------------------
// Cascaded slew limiter with bias - self-checking testbench
// Streams stereo pairs through the limiter under a series of register
// settings. These include bypass, clamp only, the sticking blend and the
// extreme thresholds. A bit-accurate model of the nine-stage chain predicts
// every output pair, and a scoreboard compares the results in order. Both
// handshakes stall at random, with stretches of back-to-back traffic.
// ----------------------------------------------------------------------------
module cascaded_slew_limiter_bias_tb;

    localparam int NSTAGE = 9;
    localparam int SW     = 24;

    localparam longint unsigned Q30_0975  = 64'd1046898278;
    localparam longint unsigned Q30_INV   = 64'd1101273666;
    localparam longint unsigned Q30_PHI   = 64'd1737350766;
    localparam longint unsigned STICK_MAX = (64'd1 << 36) - 64'd1;

    localparam longint S24_MIN = -64'sd8388608;
    localparam longint S24_MAX = 64'sd8388607;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint S32_MAX = 64'sd2147483647;

    localparam logic signed [SW-1:0] PEAK_POS = 24'sh7FFFFF;
    localparam logic signed [SW-1:0] PEAK_NEG = 24'sh800000;

    localparam logic [csl_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct packed {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
    } pair_t;

    class slew_tracker;
        bit           en_r;
        logic [23:0]  base_r;
        logic [31:0]  recip_r;
        longint       hist [2][NSTAGE];
        longint       limits [NSTAGE];
        pair_t        pending_pairs [$];
        int           errors;
        int           taken;
        int           stick_hits;
        int           clamp_hits;

        function new();
            en_r    = 1'b0;
            base_r  = 24'd4194304;
            recip_r = 32'd0;
            foreach (hist[c, k]) hist[c][k] = 64'sd0;
            errors     = 0;
            taken      = 0;
            stick_hits = 0;
            clamp_hits = 0;
        endfunction

        function void write_reg(logic [csl_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] data);
            case (idx)
                csl_pkg::CFG_ENABLE:           en_r    = data[0];
                csl_pkg::CFG_BASE_THRESHOLD:   base_r  = data[23:0];
                csl_pkg::CFG_UNDER_BIAS_RECIP: recip_r = data;
                default: ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        // signed value times an unsigned Q1.30 factor, round half away from zero
        function longint scale_q30(longint v, longint unsigned c);
            longint unsigned mag;
            longint unsigned rnd;
            if (v < 0) mag = -v;
            else mag = v;
            rnd = (mag * c + (64'd1 << 29)) >> 30;
            return (v < 0) ? -longint'(rnd) : longint'(rnd);
        endfunction

        function longint run_stages(int ch, longint x);
            longint          p;
            longint          target;
            longint          diff;
            longint          lo;
            longint          hi;
            longint unsigned d;
            longint unsigned s30;
            longint unsigned rcp;
            int              k;
            rcp = 64'(recip_r);
            for (k = 0; k < NSTAGE; k++)
            begin
                p = hist[ch][k];
                if (rcp != 0)
                begin
                    target = clip(scale_q30(p, Q30_INV), S32_MIN, S32_MAX);
                    diff   = x - target;
                    if (diff < 0) d = -diff;
                    else d = diff;
                    if (d <= STICK_MAX / rcp)
                    begin
                        s30 = (d * rcp) >> 6;
                        x   = clip(target + scale_q30(diff, s30), S32_MIN, S32_MAX);
                        stick_hits++;
                    end
                end
                lo = clip(p - limits[k], S32_MIN, S32_MAX);
                hi = clip(p + limits[k], S32_MIN, S32_MAX);
                if (x < lo || x > hi) clamp_hits++;
                x = clip(x, lo, hi);
                hist[ch][k] = clip(scale_q30(x, Q30_0975), S24_MIN, S24_MAX);
            end
            return x;
        endfunction

        function void note_sample(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
            longint unsigned t;
            longint          xl;
            longint          xr;
            pair_t           want;
            int              k;
            xl = longint'(l);
            xr = longint'(r);
            if (en_r)
            begin
                t = 64'(base_r);
                for (k = NSTAGE - 1; k >= 0; k--)
                begin
                    limits[k] = longint'((t + 64'd2) >> 2);
                    t = (t * Q30_PHI + (64'd1 << 29)) >> 30;
                    if (t > 64'd2147483647) t = 64'd2147483647;
                end
                xl = run_stages(0, xl);
                xr = run_stages(1, xr);
            end
            want.left  = SW'(clip(xl, S24_MIN, S24_MAX));
            want.right = SW'(clip(xr, S24_MIN, S24_MAX));
            pending_pairs.push_back(want);
        endfunction

        function void check_pair(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
            pair_t want;
            if (pending_pairs.size() == 0)
            begin
                $display("%0t: unexpected output pair left %0d right %0d", $time, l, r);
                errors++;
                return;
            end
            want = pending_pairs.pop_front();
            taken++;
            if (l !== want.left)
            begin
                $display("%0t: out_left expected %0d, got %0d", $time, want.left, l);
                errors++;
            end
            if (r !== want.right)
            begin
                $display("%0t: out_right expected %0d, got %0d", $time, want.right, r);
                errors++;
            end
        endfunction
    endclass

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic signed [SW-1:0]             sample_left;
    logic signed [SW-1:0]             sample_right;
    logic                             out_valid;
    logic                             out_ready;
    logic signed [SW-1:0]             out_left;
    logic signed [SW-1:0]             out_right;
    logic                             cfg_we;
    logic [csl_pkg::CFG_INDEX_W-1:0]  cfg_index;
    logic [31:0]                      cfg_data;

    slew_tracker          sb;
    int                   cycles;
    int                   sent;
    int                   settings;
    bit                   in_steady;
    bit                   out_steady;
    logic signed [SW-1:0] walk_l;
    logic signed [SW-1:0] walk_r;

    cascaded_slew_limiter_bias i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample_left  (sample_left),
        .sample_right (sample_right),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_left     (out_left),
        .out_right    (out_right),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int draw_gap(bit steady);
        if (steady) return 0;
        return $urandom_range(0, 15);
    endfunction

    function automatic logic signed [SW-1:0] next_sample(logic signed [SW-1:0] cur, int span);
        longint v;
        case ($urandom_range(0, 19))
            0: return PEAK_POS;
            1: return PEAK_NEG;
            2, 3, 4:
            begin
                v = longint'($urandom());
                return v[SW-1:0];
            end
            default:
            begin
                v = longint'(cur) + longint'($urandom_range(0, 2 * span)) - longint'(span);
                if (v > S24_MAX) v = S24_MAX;
                if (v < S24_MIN) v = S24_MIN;
                return v[SW-1:0];
            end
        endcase
    endfunction

    task automatic send_pair(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r);
        int gap;
        if ($urandom_range(0, 29) == 0) in_steady = !in_steady;
        gap = draw_gap(in_steady);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        sample_left  <= l;
        sample_right <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_sample(l, r);
        sent++;
    endtask

    // drop valid, wait for every pending pair, then let the sequencer settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_pairs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [31:0] en_word, input logic [31:0] base_word,
                                input logic [31:0] recip_word);
        logic [csl_pkg::CFG_INDEX_W-1:0] idx [4];
        logic [31:0]                     val [4];
        int                              i;
        idx[0] = csl_pkg::CFG_ENABLE;
        idx[1] = csl_pkg::CFG_BASE_THRESHOLD;
        idx[2] = csl_pkg::CFG_UNDER_BIAS_RECIP;
        idx[3] = CFG_UNUSED;
        val[0] = en_word;
        val[1] = base_word;
        val[2] = recip_word;
        val[3] = $urandom();
        drain();
        for (i = 0; i < 4; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            sb.write_reg(idx[i], val[i]);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: run timed out after %0d cycles", $time, cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int stall;
        out_ready  = 1'b0;
        out_steady = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 29) == 0) out_steady = !out_steady;
            stall = draw_gap(out_steady);
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                @(posedge clk);
                while (!out_valid) @(posedge clk);
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            sb.check_pair(out_left, out_right);
        end
    end

    initial
    begin
        int          p;
        int          n;
        int          span;
        logic [31:0] en_word;
        logic [31:0] base_word;
        logic [31:0] recip_word;
        sb           = new();
        sent         = 0;
        settings     = 0;
        in_steady    = 1'b0;
        walk_l       = '0;
        walk_r       = '0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        sample_left  = '0;
        sample_right = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // bypass with reset values
        send_pair(PEAK_POS, PEAK_NEG);
        send_pair(PEAK_NEG, PEAK_POS);
        send_pair(24'sd0, -24'sd1);
        send_pair(-24'sd1, 24'sd1);
        send_pair(24'sh400000, -24'sh400000);

        // clamp only, junk in the upper register bits
        program_regs(32'hFFFF_FFFF, 32'hFF40_0000, 32'h0);
        send_pair(PEAK_POS, PEAK_NEG);
        send_pair(PEAK_POS, PEAK_NEG);
        send_pair(PEAK_NEG, PEAK_POS);
        send_pair(24'sd0, 24'sd0);
        send_pair(24'sd1, -24'sd1);
        send_pair(-24'sd1, 24'sd1);

        // zero threshold, widest sticking factor
        program_regs(32'h1, 32'h0, 32'hFFFF_FFFF);
        send_pair(PEAK_POS, PEAK_NEG);
        send_pair(PEAK_NEG, PEAK_POS);
        send_pair(24'sd0, 24'sd0);
        send_pair(-24'sd1, -24'sd1);

        // widest threshold, unit sticking width
        program_regs(32'h3, 32'hFFFF_FFFF, 32'h0001_0000);
        send_pair(PEAK_POS, PEAK_NEG);
        send_pair(PEAK_NEG, PEAK_POS);
        send_pair(24'sd0, -24'sd1);
        send_pair(24'sd1, 24'sd1);
        send_pair(PEAK_POS, PEAK_POS);

        // bypass again; history must survive
        program_regs(32'hFFFF_FFFE, 32'h0010_0000, 32'h0000_8000);
        send_pair(24'sh123456, -24'sh123456);
        send_pair(PEAK_NEG, PEAK_NEG);

        for (p = 0; p < 10; p++)
        begin
            case ($urandom_range(0, 4))
                0: base_word = 32'h0;
                1: base_word = $urandom_range(1, 65535);
                2: base_word = $urandom_range(65536, 4194304);
                3: base_word = $urandom();
                default: base_word = 32'hFFFF_FFFF;
            endcase
            case ($urandom_range(0, 4))
                0: recip_word = 32'h0;
                1: recip_word = $urandom_range(1, 65536);
                2: recip_word = $urandom_range(65536, 1 << 22);
                3: recip_word = $urandom();
                default: recip_word = 32'hFFFF_FFFF;
            endcase
            if (p < 3) recip_word = $urandom_range(4096, 1 << 20);
            en_word    = $urandom();
            en_word[0] = (p % 5 != 4);
            case ($urandom_range(0, 3))
                0: span = 256;
                1: span = 4096;
                2: span = 65536;
                default: span = 1 << 20;
            endcase
            program_regs(en_word, base_word, recip_word);
            for (n = 0; n < 140; n++)
            begin
                walk_l = next_sample(walk_l, span);
                walk_r = next_sample(walk_r, span);
                send_pair(walk_l, walk_r);
            end
        end

        drain();
        $display("Sent %0d stereo pairs over %0d register settings, %0d results checked.",
                 sent, settings, sb.taken);
        $display("Sticking blend engaged %0d times, stage clamp %0d times, %0d mismatches.",
                 sb.stick_hits, sb.clamp_hits, sb.errors);
        if (sb.errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/csl_pkg.sv
src/csl_seq.sv
src/csl_thresh.sv
src/csl_lane.sv
src/cascaded_slew_limiter_bias.sv
tb/sv/cascaded_slew_limiter_bias_tb.sv
